### src/rsm_pkg.sv
`default_nettype none
package rsm_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int WORD_W       = 32;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic [3:0] step_t;

    localparam step_t STEP_IDLE      = 4'd0;
    localparam step_t STEP_INS_CHK   = 4'd1;
    localparam step_t STEP_INS_SCAN  = 4'd2;
    localparam step_t STEP_INS_WR    = 4'd3;
    localparam step_t STEP_REM_CLR   = 4'd4;
    localparam step_t STEP_REM_SCAN  = 4'd5;
    localparam step_t STEP_REM_MISS  = 4'd6;
    localparam step_t STEP_REM_RD    = 4'd7;
    localparam step_t STEP_REM_WR    = 4'd8;
    localparam step_t STEP_SMP_CHK   = 4'd9;
    localparam step_t STEP_SMP_DIV   = 4'd10;
    localparam step_t STEP_SMP_RD    = 4'd11;
    localparam step_t STEP_SMP_OUT   = 4'd12;
    localparam step_t STEP_SMP_EMPTY = 4'd13;
    localparam step_t STEP_NOP_CMD   = 4'd14;
    localparam step_t STEP_INS_FULL  = 4'd15;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLR_SCAN,
        OP_SCAN,
        OP_APPEND,
        OP_READ_LAST,
        OP_WR_SLOT,
        OP_DIV_START,
        OP_READ_REM,
        OP_EMIT_NONE,
        OP_EMIT_FULL,
        OP_EMIT_EMPTY,
        OP_EMIT_SAMPLE
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_GOTO,
        C_IF_FULL,
        C_IF_EMPTY,
        C_WAIT_DIV,
        C_SCAN
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic hit;
        logic scan_done;
        logic div_idle;
    } dp_stat_t;

    function automatic ctrl_t ucode(input step_t pc);
        ctrl_t w;
        w = '{op: OP_NOP, cond: C_GOTO, target: STEP_IDLE};
        unique case (pc)
            STEP_IDLE:      w = '{op: OP_NOP,         cond: C_GOTO,     target: STEP_IDLE};
            STEP_INS_CHK:   w = '{op: OP_CLR_SCAN,    cond: C_IF_FULL,  target: STEP_INS_FULL};
            STEP_INS_SCAN:  w = '{op: OP_SCAN,        cond: C_SCAN,     target: STEP_INS_WR};
            STEP_INS_WR:    w = '{op: OP_APPEND,      cond: C_GOTO,     target: STEP_IDLE};
            STEP_REM_CLR:   w = '{op: OP_CLR_SCAN,    cond: C_NEXT,     target: STEP_IDLE};
            STEP_REM_SCAN:  w = '{op: OP_SCAN,        cond: C_SCAN,     target: STEP_REM_RD};
            STEP_REM_MISS:  w = '{op: OP_EMIT_NONE,   cond: C_GOTO,     target: STEP_IDLE};
            STEP_REM_RD:    w = '{op: OP_READ_LAST,   cond: C_NEXT,     target: STEP_IDLE};
            STEP_REM_WR:    w = '{op: OP_WR_SLOT,     cond: C_GOTO,     target: STEP_IDLE};
            STEP_SMP_CHK:   w = '{op: OP_DIV_START,   cond: C_IF_EMPTY, target: STEP_SMP_EMPTY};
            STEP_SMP_DIV:   w = '{op: OP_NOP,         cond: C_WAIT_DIV, target: STEP_SMP_RD};
            STEP_SMP_RD:    w = '{op: OP_READ_REM,    cond: C_NEXT,     target: STEP_IDLE};
            STEP_SMP_OUT:   w = '{op: OP_EMIT_SAMPLE, cond: C_GOTO,     target: STEP_IDLE};
            STEP_SMP_EMPTY: w = '{op: OP_EMIT_EMPTY,  cond: C_GOTO,     target: STEP_IDLE};
            STEP_NOP_CMD:   w = '{op: OP_EMIT_NONE,   cond: C_GOTO,     target: STEP_IDLE};
            STEP_INS_FULL:  w = '{op: OP_EMIT_FULL,   cond: C_GOTO,     target: STEP_IDLE};
            default:        w = '{op: OP_NOP,         cond: C_GOTO,     target: STEP_IDLE};
        endcase
        return w;
    endfunction

    function automatic step_t entry(input logic [1:0] cmd);
        step_t s;
        s = STEP_NOP_CMD;
        unique case (cmd)
            CMD_INSERT: s = STEP_INS_CHK;
            CMD_REMOVE: s = STEP_REM_CLR;
            CMD_SAMPLE: s = STEP_SMP_CHK;
            default:    s = STEP_NOP_CMD;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

### src/rsm_mem.sv
`default_nettype none
module rsm_mem #(
    parameter int DEPTH = rsm_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             waddr,
    input  wire logic [rsm_pkg::WORD_W-1:0] wdata,
    input  wire logic [AW-1:0]             raddr,
    output logic      [rsm_pkg::WORD_W-1:0] rdata
);

    logic [rsm_pkg::WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### src/rsm_div.sv
`default_nettype none
module rsm_div #(
    parameter int CW = 7
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [rsm_pkg::WORD_W-1:0] dividend,
    input  wire logic [CW-1:0]              divisor,
    output logic                            idle,
    output logic      [CW-1:0]              rem
);

    localparam int NW = $clog2(rsm_pkg::WORD_W);

    logic                       run_reg, run_next;
    logic [NW-1:0]              cnt_reg, cnt_next;
    logic [rsm_pkg::WORD_W-1:0] q_reg, q_next;
    logic [CW-1:0]              rem_reg, rem_next;
    logic [CW-1:0]              div_reg, div_next;
    logic [CW:0]                trial;

    // one dividend bit per cycle, restoring
    always_comb
    begin
        run_next = run_reg;
        cnt_next = cnt_reg;
        q_next   = q_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        trial    = {rem_reg, q_reg[rsm_pkg::WORD_W-1]};
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            q_next   = dividend;
            rem_next = '0;
            div_next = divisor;
        end
        else if (run_reg)
        begin
            q_next = {q_reg[rsm_pkg::WORD_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = CW'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[CW-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == NW'(rsm_pkg::WORD_W - 1))
            begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign idle = !run_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

### src/rsm_seq.sv
`default_nettype none
module rsm_seq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [1:0]        command,
    input  wire rsm_pkg::dp_stat_t stat,
    output rsm_pkg::op_t           op,
    output logic                   busy
);

    rsm_pkg::step_t pc_reg, pc_next;
    rsm_pkg::ctrl_t word;

    always_comb
    begin
        word    = rsm_pkg::ucode(pc_reg);
        pc_next = pc_reg + 1'b1;
        if (pc_reg == rsm_pkg::STEP_IDLE)
        begin
            pc_next = start ? rsm_pkg::entry(command) : rsm_pkg::STEP_IDLE;
        end
        else
        begin
            unique case (word.cond)
                rsm_pkg::C_NEXT:     pc_next = pc_reg + 1'b1;
                rsm_pkg::C_GOTO:     pc_next = word.target;
                rsm_pkg::C_IF_FULL:  pc_next = stat.full ? word.target : pc_reg + 1'b1;
                rsm_pkg::C_IF_EMPTY: pc_next = stat.empty ? word.target : pc_reg + 1'b1;
                rsm_pkg::C_WAIT_DIV: pc_next = stat.div_idle ? word.target : pc_reg;
                rsm_pkg::C_SCAN:
                begin
                    priority if (stat.hit)
                    begin
                        pc_next = word.target;
                    end
                    else if (stat.scan_done)
                    begin
                        pc_next = pc_reg + 1'b1;
                    end
                    else
                    begin
                        pc_next = pc_reg;
                    end
                end
                default:             pc_next = rsm_pkg::STEP_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= rsm_pkg::STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign op   = word.op;
    assign busy = (pc_reg != rsm_pkg::STEP_IDLE);

endmodule
`default_nettype wire

### src/random_sampling_multiset.sv
`default_nettype none
// Multiset of up to CAPACITY signed 32-bit values in a dense store. A request is taken
// when start is high and busy is low; busy then stays high until the result is ready.
// Insert and remove scan the store one entry per cycle through its single read port, and
// sample runs a one-bit-per-cycle remainder unit. The result is shown on flag, sample_value
// and status for exactly one cycle with done high; the receiver cannot stall it, and a
// new request may be taken in that same cycle.
module random_sampling_multiset #(
    parameter int CAPACITY = rsm_pkg::CAPACITY_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic        [1:0]                 command,
    input  wire logic signed [rsm_pkg::WORD_W-1:0] value,
    input  wire logic        [rsm_pkg::WORD_W-1:0] random_word,
    output logic                                   done,
    output logic                                   flag,
    output logic signed      [rsm_pkg::WORD_W-1:0] sample_value,
    output logic             [1:0]                 status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    logic                       accept;
    rsm_pkg::op_t               op;
    rsm_pkg::dp_stat_t          stat;

    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic                       cmp_valid_reg, cmp_valid_next;
    logic                       found_reg, found_next;
    logic                       done_reg, done_next;
    logic [AW-1:0]              cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0]              slot_reg, slot_next;
    logic [rsm_pkg::WORD_W-1:0] value_reg, random_reg;
    logic                       flag_reg, flag_next;
    logic [rsm_pkg::WORD_W-1:0] sample_reg, sample_next;
    logic [1:0]                 status_reg, status_next;

    logic                       we;
    logic [AW-1:0]              waddr, raddr;
    logic [rsm_pkg::WORD_W-1:0] wdata, rdata;
    logic                       div_start, div_idle;
    logic [CW-1:0]              div_rem;

    assign accept = start && !busy;

    assign stat.full      = (count_reg == CW'(CAPACITY));
    assign stat.empty     = (count_reg == '0);
    assign stat.hit       = cmp_valid_reg && (rdata == value_reg);
    assign stat.scan_done = !cmp_valid_reg && (idx_reg >= count_reg);
    assign stat.div_idle  = div_idle;

    rsm_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .command (command),
        .stat    (stat),
        .op      (op),
        .busy    (busy)
    );

    rsm_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    rsm_div #(
        .CW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (random_reg),
        .divisor  (count_reg),
        .idle     (div_idle),
        .rem      (div_rem)
    );

    assign div_start = (op == rsm_pkg::OP_DIV_START) && !stat.empty;

    always_comb
    begin
        unique case (op)
            rsm_pkg::OP_READ_LAST: raddr = AW'(count_reg - 1'b1);
            rsm_pkg::OP_READ_REM:  raddr = div_rem[AW-1:0];
            default:               raddr = idx_reg[AW-1:0];
        endcase
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = count_reg[AW-1:0];
        wdata = value_reg;
        unique case (op)
            rsm_pkg::OP_APPEND:
            begin
                we = 1'b1;
            end
            rsm_pkg::OP_WR_SLOT:
            begin
                we    = 1'b1;
                waddr = slot_reg;
                wdata = rdata;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        done_next      = 1'b0;
        flag_next      = flag_reg;
        sample_next    = sample_reg;
        status_next    = status_reg;
        unique case (op)
            rsm_pkg::OP_CLR_SCAN:
            begin
                idx_next       = '0;
                cmp_valid_next = 1'b0;
                found_next     = 1'b0;
            end
            rsm_pkg::OP_SCAN:
            begin
                // issue one read per cycle, compare the previous one
                cmp_idx_next   = idx_reg[AW-1:0];
                cmp_valid_next = (idx_reg < count_reg);
                if (idx_reg < count_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (stat.hit)
                begin
                    found_next = 1'b1;
                    slot_next  = cmp_idx_reg;
                end
            end
            rsm_pkg::OP_APPEND:
            begin
                count_next  = count_reg + 1'b1;
                done_next   = 1'b1;
                flag_next   = !found_reg;
                sample_next = '0;
                status_next = rsm_pkg::ST_OK;
            end
            rsm_pkg::OP_WR_SLOT:
            begin
                count_next  = count_reg - 1'b1;
                done_next   = 1'b1;
                flag_next   = 1'b1;
                sample_next = '0;
                status_next = rsm_pkg::ST_OK;
            end
            rsm_pkg::OP_EMIT_NONE:
            begin
                done_next   = 1'b1;
                flag_next   = 1'b0;
                sample_next = '0;
                status_next = rsm_pkg::ST_OK;
            end
            rsm_pkg::OP_EMIT_FULL:
            begin
                done_next   = 1'b1;
                flag_next   = 1'b0;
                sample_next = '0;
                status_next = rsm_pkg::ST_FULL;
            end
            rsm_pkg::OP_EMIT_EMPTY:
            begin
                done_next   = 1'b1;
                flag_next   = 1'b0;
                sample_next = '0;
                status_next = rsm_pkg::ST_EMPTY;
            end
            rsm_pkg::OP_EMIT_SAMPLE:
            begin
                done_next   = 1'b1;
                flag_next   = 1'b0;
                sample_next = rdata;
                status_next = rsm_pkg::ST_OK;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        slot_reg    <= slot_next;
        flag_reg    <= flag_next;
        sample_reg  <= sample_next;
        status_reg  <= status_next;
        if (accept)
        begin
            value_reg  <= value;
            random_reg <= random_word;
        end
    end

    assign done         = done_reg;
    assign flag         = flag_reg;
    assign sample_value = sample_reg;
    assign status       = status_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a request in flight");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == rsm_pkg::ST_FULL) |-> (count_reg == CW'(CAPACITY)))
        else $error("full status while store has room");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == rsm_pkg::ST_EMPTY) |-> (count_reg == '0))
        else $error("empty status while store holds entries");
`endif

endmodule
`default_nettype wire
